FILE: src/aimd_pkg.sv
`timescale 1ns / 1ps
// Shared constants for the AIMD congestion window block.
package aimd_pkg;

	localparam logic [31:0] Q16_MAX        = 32'hFFFF_FFFF;
	localparam logic [31:0] CWND_RESET     = 32'd65536;
	localparam logic [31:0] MIN_RTT_RESET  = 32'd117;
	localparam logic [15:0] MD_RESET       = 16'd512;
	localparam logic [15:0] AI_RESET       = 16'd256;
	localparam logic [15:0] TIMEOUT_RESET  = 16'd117;
	localparam logic [31:0] MIN_WIN_RESET  = 32'd196608;

	localparam int DVD_W = 40;

	typedef enum logic [1:0] {
		REG_MD_DIV  = 2'd0,
		REG_AI_GAIN = 2'd1,
		REG_TIMEOUT = 2'd2,
		REG_MIN_WIN = 2'd3
	} cfg_reg_t;

	typedef enum logic {
		REQ_SEND = 1'b0,
		REQ_ACK  = 1'b1
	} req_t;

endpackage

FILE: src/aimd_window_with_timeout_scan.sv
`timescale 1ns / 1ps
// AIMD congestion window with outstanding table and stale-entry scan.
//
//  channel  | handshake            | payload
//  ---------+----------------------+----------------------------------------------
//  request  | start / busy         | req_type, seq_num, send_time, ack_time, now_time
//  result   | done (1-cycle pulse) | win_int, did_decrease, min_rtt_out, table_full
//  config   | cfg_we               | cfg_idx, cfg_wdata
//
// A send makes one table pass through the registered memory read port, then
// the table write. An ack makes the table pass, then the increase division
// and the decrease division where each applies, all on one shared restoring
// divider (one bit per cycle).
// Reset clears the window state and all valid bits at once; no clearing pass.
// The receiver cannot stall: done lasts one cycle, with busy low.
module aimd_window_with_timeout_scan #(
	parameter int TABLE_DEPTH = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        req_type,
	input  logic [31:0] seq_num,
	input  logic [31:0] send_time,
	input  logic [31:0] ack_time,
	input  logic [31:0] now_time,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_idx,
	input  logic [31:0] cfg_wdata,
	output logic        done,
	output logic [15:0] win_int,
	output logic        did_decrease,
	output logic [31:0] min_rtt_out,
	output logic        table_full
);
	import aimd_pkg::*;

	localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CW = $clog2(TABLE_DEPTH + 1);

	typedef enum logic [3:0] {
		ST_IDLE, ST_SCAN, ST_WRITE, ST_GROW, ST_GADD,
		ST_CHECK, ST_SHRINK, ST_SSAT, ST_FLOOR, ST_FIN
	} state_t;

	state_t state_q;

	logic [15:0] md_q, ai_q, tmo_q;
	logic [31:0] minwin_q;

	logic [31:0] cwnd_q, min_rtt_q, last_chk_q;
	logic [TABLE_DEPTH-1:0] vld_q;
	logic [31:0] seq_mem [TABLE_DEPTH];
	logic [31:0] time_mem [TABLE_DEPTH];

	logic        ack_q, grow_q, chk_q, stale_q, hit_q, free_q, dec_q, full_q, done_q;
	logic [31:0] seq_q, stime_q, now_q;
	logic [AW-1:0] hit_idx_q, free_idx_q;
	logic [CW-1:0] cnt_q;

	logic          rd_vld_s1;
	logic [AW-1:0] idx_s1;
	logic [31:0]   rseq_s1, rtime_s1;

	logic [DVD_W-1:0] dvd_q;
	logic [31:0]      dvs_q, rem_q;
	logic [5:0]       dcnt_q;

	// accept-time arithmetic
	logic [31:0] rtt, min_rtt_nx;
	assign rtt        = ack_time - send_time;
	assign min_rtt_nx = (rtt < min_rtt_q) ? rtt : min_rtt_q;

	// scan evaluation
	logic        ent_vld, seq_eq, ent_stale;
	logic [31:0] age;
	assign ent_vld   = rd_vld_s1 && vld_q[idx_s1];
	assign seq_eq    = (rseq_s1 == seq_q);
	assign age       = now_q - rtime_s1;
	assign ent_stale = ent_vld && !seq_eq && (age > {16'd0, tmo_q});

	// shared restoring divider step
	logic [32:0] rem_sh, rem_df;
	logic        q_bit;
	assign rem_sh = {rem_q, dvd_q[DVD_W-1]};
	assign rem_df = rem_sh - {1'b0, dvs_q};
	assign q_bit  = (rem_sh >= {1'b0, dvs_q});

	logic [40:0] gsum;
	assign gsum = {9'd0, cwnd_q} + {1'b0, dvd_q};

	logic          mem_we;
	logic [AW-1:0] wr_idx;
	assign mem_we = (state_q == ST_WRITE) && (hit_q || free_q);
	assign wr_idx = hit_q ? hit_idx_q : free_idx_q;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			seq_mem[wr_idx]  <= seq_q;
			time_mem[wr_idx] <= stime_q;
		end
		rseq_s1  <= seq_mem[cnt_q[AW-1:0]];
		rtime_s1 <= time_mem[cnt_q[AW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			md_q       <= MD_RESET;
			ai_q       <= AI_RESET;
			tmo_q      <= TIMEOUT_RESET;
			minwin_q   <= MIN_WIN_RESET;
			cwnd_q     <= CWND_RESET;
			min_rtt_q  <= MIN_RTT_RESET;
			last_chk_q <= '0;
			vld_q      <= '0;
			ack_q      <= 1'b0;
			grow_q     <= 1'b0;
			chk_q      <= 1'b0;
			stale_q    <= 1'b0;
			hit_q      <= 1'b0;
			free_q     <= 1'b0;
			dec_q      <= 1'b0;
			full_q     <= 1'b0;
			done_q     <= 1'b0;
			cnt_q      <= '0;
			rd_vld_s1  <= 1'b0;
			idx_s1     <= '0;
			dcnt_q     <= '0;
		end else begin
			done_q <= 1'b0;
			if (cfg_we) begin
				unique case (cfg_reg_t'(cfg_idx))
					REG_MD_DIV:  md_q     <= cfg_wdata[15:0];
					REG_AI_GAIN: ai_q     <= cfg_wdata[15:0];
					REG_TIMEOUT: tmo_q    <= cfg_wdata[15:0];
					REG_MIN_WIN: minwin_q <= cfg_wdata;
				endcase
			end
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						ack_q     <= (req_t'(req_type) == REQ_ACK);
						seq_q     <= seq_num;
						stime_q   <= send_time;
						now_q     <= now_time;
						hit_q     <= 1'b0;
						free_q    <= 1'b0;
						stale_q   <= 1'b0;
						dec_q     <= 1'b0;
						full_q    <= 1'b0;
						cnt_q     <= '0;
						rd_vld_s1 <= 1'b0;
						grow_q    <= 1'b0;
						chk_q     <= 1'b0;
						if (req_t'(req_type) == REQ_ACK) begin
							min_rtt_q <= min_rtt_nx;
							grow_q    <= (rtt < {16'd0, tmo_q});
							if ((now_time - last_chk_q) > min_rtt_nx) begin
								chk_q      <= 1'b1;
								last_chk_q <= now_time;
							end
						end
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (cnt_q != CW'(TABLE_DEPTH)) begin
						rd_vld_s1 <= 1'b1;
						idx_s1    <= cnt_q[AW-1:0];
						cnt_q     <= cnt_q + 1'b1;
					end else begin
						rd_vld_s1 <= 1'b0;
					end
					if (ack_q) begin
						if (ent_vld && seq_eq)
							vld_q[idx_s1] <= 1'b0;
						if (ent_stale)
							stale_q <= 1'b1;
					end else if (ent_vld) begin
						if (!hit_q && seq_eq) begin
							hit_q     <= 1'b1;
							hit_idx_q <= idx_s1;
						end
					end else if (rd_vld_s1 && !free_q) begin
						free_q     <= 1'b1;
						free_idx_q <= idx_s1;
					end
					if (cnt_q == CW'(TABLE_DEPTH) && !rd_vld_s1) begin
						if (!ack_q) begin
							state_q <= ST_WRITE;
						end else if (!grow_q) begin
							state_q <= ST_CHECK;
						end else if (cwnd_q == '0) begin
							cwnd_q  <= Q16_MAX;
							state_q <= ST_CHECK;
						end else begin
							dvd_q   <= {ai_q, 24'd0};
							dvs_q   <= cwnd_q;
							rem_q   <= '0;
							dcnt_q  <= '0;
							state_q <= ST_GROW;
						end
					end
				end
				ST_WRITE: begin
					if (hit_q || free_q)
						vld_q[wr_idx] <= 1'b1;
					else
						full_q <= 1'b1;
					state_q <= ST_FIN;
				end
				ST_GROW, ST_SHRINK: begin
					rem_q  <= q_bit ? rem_df[31:0] : rem_sh[31:0];
					dvd_q  <= {dvd_q[DVD_W-2:0], q_bit};
					dcnt_q <= dcnt_q + 1'b1;
					if (dcnt_q == 6'(DVD_W - 1))
						state_q <= (state_q == ST_GROW) ? ST_GADD : ST_SSAT;
				end
				ST_GADD: begin
					cwnd_q  <= (gsum[40:32] != '0) ? Q16_MAX : gsum[31:0];
					state_q <= ST_CHECK;
				end
				ST_CHECK: begin
					if (chk_q && stale_q) begin
						dec_q <= 1'b1;
						if (md_q != '0) begin
							dvd_q   <= {cwnd_q, 8'd0};
							dvs_q   <= {16'd0, md_q};
							rem_q   <= '0;
							dcnt_q  <= '0;
							state_q <= ST_SHRINK;
						end else begin
							state_q <= ST_FLOOR;
						end
					end else begin
						state_q <= ST_FIN;
					end
				end
				ST_SSAT: begin
					cwnd_q  <= (dvd_q[39:32] != '0) ? Q16_MAX : dvd_q[31:0];
					state_q <= ST_FLOOR;
				end
				ST_FLOOR: begin
					if (cwnd_q < minwin_q)
						cwnd_q <= minwin_q;
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					done_q  <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign busy         = (state_q != ST_IDLE);
	assign done         = done_q;
	assign win_int      = cwnd_q[31:16];
	assign did_decrease = dec_q;
	assign min_rtt_out  = min_rtt_q;
	assign table_full   = full_q;

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy) else $error("result transfer while busy");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy && !done) else $error("accepted request did not start");

	a_floor: assert property (@(posedge clk) disable iff (!arst_n)
		done && did_decrease |-> cwnd_q >= minwin_q) else $error("window below floor");

	a_full_send: assert property (@(posedge clk) disable iff (!arst_n)
		done && table_full |-> !did_decrease && !ack_q) else $error("bad drop flag");

endmodule
